FILE: rtl/core/wsd_pkg.sv
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned LeftW   = 4;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  localparam logic [LeftW-1:0] LEN16_BYTES = 4'd2;
  localparam logic [LeftW-1:0] LEN64_BYTES = 4'd8;
  localparam logic [LeftW-1:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic               valid;
    logic [ByteW-1:0]   payload_byte;
    logic [OpcodeW-1:0] frame_opcode;
    logic               final_fragment;
    logic               frame_empty;
    logic               frame_last;
  } result_t;

endpackage

FILE: rtl/core/wsd_parse.sv
module wsd_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [wsd_pkg::ByteW-1:0] byte_in,
  output wsd_pkg::result_t          res
);

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [wsd_pkg::OpcodeW-1:0]   opcode_r, opcode_nxt;
  logic                          fin_r, fin_nxt;
  logic                          mask_r, mask_nxt;
  logic [wsd_pkg::LenW-1:0]      len_r, len_nxt;
  logic [wsd_pkg::LeftW-1:0]     left_r, left_nxt;
  logic [wsd_pkg::KeyW-1:0]      key_r, key_nxt;
  logic [1:0]                    pos_r, pos_nxt;

  logic                          len_done;
  logic                          key_done;
  logic                          hdr_done;
  logic [wsd_pkg::ByteW-1:0]     key_byte;

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    len_done   = 1'b0;
    key_done   = 1'b0;
    key_byte   = '0;

    res.valid          = 1'b0;
    res.payload_byte   = '0;
    res.frame_opcode   = opcode_r;
    res.final_fragment = fin_r;
    res.frame_empty    = 1'b0;
    res.frame_last     = 1'b0;

    case (phase_r)
      PH_HDR1: begin
        mask_nxt = byte_in[7];
        key_nxt  = '0;
        if (byte_in[6:0] == wsd_pkg::LEN16_CODE) begin
          len_nxt   = '0;
          left_nxt  = wsd_pkg::LEN16_BYTES;
          phase_nxt = PH_EXTLEN;
        end else if (byte_in[6:0] == wsd_pkg::LEN64_CODE) begin
          len_nxt   = '0;
          left_nxt  = wsd_pkg::LEN64_BYTES;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_nxt  = {{(wsd_pkg::LenW-7){1'b0}}, byte_in[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_nxt  = {len_r[wsd_pkg::LenW-wsd_pkg::ByteW-1:0], byte_in};
        left_nxt = left_r - 1'b1;
        len_done = (left_nxt == '0);
      end
      PH_KEY: begin
        key_nxt  = {key_r[wsd_pkg::KeyW-wsd_pkg::ByteW-1:0], byte_in};
        left_nxt = left_r - 1'b1;
        key_done = (left_nxt == '0);
      end
      PH_DATA: begin
        // Key byte zero sits in the top byte of the key register.
        if (mask_r) begin
          key_byte = key_r[(2'd3 - pos_r)*wsd_pkg::ByteW +: wsd_pkg::ByteW];
        end
        pos_nxt          = pos_r + 1'b1;
        len_nxt          = len_r - 1'b1;
        res.valid        = 1'b1;
        res.payload_byte = byte_in ^ key_byte;
        res.frame_last   = (len_nxt == '0);
        if (len_nxt == '0) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        fin_nxt    = byte_in[7];
        opcode_nxt = byte_in[3:0];
        phase_nxt  = PH_HDR1;
      end
    endcase

    // Length settled: fetch the mask key or close the header.
    if (len_done && mask_nxt) begin
      phase_nxt = PH_KEY;
      left_nxt  = wsd_pkg::KEY_BYTES;
    end
    hdr_done = (len_done && !mask_nxt) || key_done;
    if (hdr_done) begin
      pos_nxt = '0;
      if (len_nxt == '0) begin
        phase_nxt       = PH_HDR0;
        res.valid       = 1'b1;
        res.frame_empty = 1'b1;
        res.frame_last  = 1'b1;
      end else begin
        phase_nxt = PH_DATA;
      end
    end

    res.valid = res.valid && step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      fin_r    <= 1'b0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      left_r   <= '0;
      key_r    <= '0;
      pos_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

FILE: rtl/core/websocket_frame_deframer.sv
// WebSocket (base framing) deframer. Feed the received stream one byte per
// in_ beat; each payload byte comes out unmasked on an out_ beat, tagged with
// the frame's opcode and FIN, with out_frame_last on the final byte of the
// frame. A zero-length frame gives a single beat with out_frame_empty and
// out_frame_last set and a zero payload byte, on the byte that ends its
// header. Header, length and key bytes give no beat otherwise. Reserved bits
// are ignored and nothing is checked. Rate is one byte per cycle sustained
// while out_ready stays high. A byte's result reaches out_ through the input
// register, then the result register. The parser's state update is
// combinational between them; its longest path is the 64-bit length
// decrement and zero test. While a result waits on out_, the input register
// still takes one byte if it is empty, then holds in_ready low until the
// result leaves.
module websocket_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wsd_pkg::ByteW-1:0]   in_stream_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wsd_pkg::ByteW-1:0]   out_payload_byte,
  output logic [wsd_pkg::OpcodeW-1:0] out_frame_opcode,
  output logic                        out_final_fragment,
  output logic                        out_frame_empty,
  output logic                        out_frame_last
);

  // Input register
  logic                      in_valid_r;
  logic [wsd_pkg::ByteW-1:0] in_byte_r;

  // Result register
  wsd_pkg::result_t          out_r;

  wsd_pkg::result_t          res;
  logic                      step;

  // Advance the parser whenever a byte is held and the result slot is free or being taken.
  assign step     = in_valid_r && (!out_r.valid || out_ready);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_stream_byte;
    end
  end

  wsd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .res     (res)
  );

  // Load a result on a step that makes one; drop the slot once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (step) begin
      out_r <= res;
    end else if (out_ready) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_valid          = out_r.valid;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_frame_opcode   = out_r.frame_opcode;
  assign out_final_fragment = out_r.final_fragment;
  assign out_frame_empty    = out_r.frame_empty;
  assign out_frame_last     = out_r.frame_last;

`ifndef SYNTH
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_empty |-> out_frame_last && (out_payload_byte == '0))
    else $error("empty-frame beat without last flag or with nonzero data");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while held byte cannot advance");

  a_held_byte_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(in_byte_r))
    else $error("held input byte lost or changed");

  a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(step))
    else $error("result appeared without a parser step");
`endif

endmodule
